// ===== sv/sha256_pkg.sv =====
`default_nettype none

package sha256_pkg;

  localparam logic [1:0] MODE_ABSORB  = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] STAT_DIGEST       = 2'd0;
  localparam logic [1:0] STAT_AFTER_FINISH = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG     = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Byte count at which the length field begins in the last block.
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] CNT_LAST  = 6'd63;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  localparam logic [31:0] K_ROUND [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_LEN,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_DONE
  } ret_t;

  typedef enum logic [1:0] {
    SH_DATA,
    SH_PAD,
    SH_ZERO,
    SH_LEN
  } shsel_t;

  typedef struct packed {
    logic       shift_en;
    shsel_t     shift_sel;
    logic [2:0] len_idx;
    logic       tot_inc;
    logic       restart;
    logic       load_wv;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_upd;
    logic       out_load;
    logic       out_err;
    logic [1:0] out_status;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic at_limit;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/sha256_dp.sv =====
`default_nettype none

module sha256_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire sha256_pkg::dp_cmd_t cmd,
  output sha256_pkg::dp_sts_t     sts,
  input  wire [7:0]               data_byte,
  output logic [31:0]             out_word,
  output logic [2:0]              out_idx,
  output logic [1:0]              out_status,
  output logic                    out_last
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // The block buffer and the message schedule share one 512-bit window:
  // bytes shift in at the bottom, and each round shifts in one new word.
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  wv_r [0:7];
  logic [31:0]  wv_nxt [0:7];
  logic [31:0]  ch_r [0:7];
  logic [31:0]  ch_nxt [0:7];
  logic [60:0]  total_r, total_nxt;

  logic [31:0] w0, w1, w9, w14, wnew;
  logic [31:0] t1, t2;
  logic [63:0] len_bits;
  logic [7:0]  sh_byte;

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign wnew = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign t1 = wv_r[7] + bsig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + sha256_pkg::K_ROUND[cmd.round_idx] + w0;
  assign t2 = bsig0(wv_r[0])
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  assign len_bits = {total_r, 3'b000};
  assign sts.at_limit = &total_r;

  always_comb begin
    case (cmd.shift_sel)
      sha256_pkg::SH_DATA: sh_byte = data_byte;
      sha256_pkg::SH_PAD:  sh_byte = sha256_pkg::PAD_BYTE;
      sha256_pkg::SH_LEN:  sh_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];
      default:             sh_byte = 8'h00;
    endcase
  end

  always_comb begin
    blk_nxt = blk_r;
    if (cmd.shift_en) begin
      blk_nxt = {blk_r[503:0], sh_byte};
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], wnew};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      wv_nxt[i] = wv_r[i];
      ch_nxt[i] = ch_r[i];
    end
    if (cmd.load_wv) begin
      for (int i = 0; i < 8; i++) begin
        wv_nxt[i] = ch_r[i];
      end
    end else if (cmd.round_en) begin
      wv_nxt[7] = wv_r[6];
      wv_nxt[6] = wv_r[5];
      wv_nxt[5] = wv_r[4];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[3] = wv_r[2];
      wv_nxt[2] = wv_r[1];
      wv_nxt[1] = wv_r[0];
      wv_nxt[0] = t1 + t2;
    end
    if (cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        ch_nxt[i] = sha256_pkg::H_INIT[i];
      end
    end else if (cmd.chain_upd) begin
      for (int i = 0; i < 8; i++) begin
        ch_nxt[i] = ch_r[i] + wv_r[i];
      end
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.restart) begin
      total_nxt = '0;
    end else if (cmd.tot_inc) begin
      total_nxt = total_r + 61'd1;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    for (int i = 0; i < 8; i++) begin
      wv_r[i] <= wv_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < 8; i++) begin
        ch_r[i] <= sha256_pkg::H_INIT[i];
      end
    end else begin
      total_r <= total_nxt;
      for (int i = 0; i < 8; i++) begin
        ch_r[i] <= ch_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_word   <= '0;
        out_idx    <= '0;
        out_status <= cmd.out_status;
        out_last   <= 1'b1;
      end else begin
        out_word   <= ch_r[cmd.out_idx];
        out_idx    <= cmd.out_idx;
        out_status <= sha256_pkg::STAT_DIGEST;
        out_last   <= (cmd.out_idx == sha256_pkg::WORD_LAST);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha256_ctrl.sv =====
`default_nettype none

module sha256_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire [1:0]               in_mode,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output sha256_pkg::dp_cmd_t     cmd,
  input  wire sha256_pkg::dp_sts_t sts
);

  sha256_pkg::state_t state_r, state_nxt;
  sha256_pkg::ret_t   ret_r, ret_nxt;
  logic [5:0] count_r, count_nxt;
  logic [2:0] len_r, len_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       done_r, done_nxt;
  logic [1:0] err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       absorb_ok;

  assign in_tready  = (state_r == sha256_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign absorb_ok  = !done_r && !sts.at_limit;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_mode)
            sha256_pkg::MODE_ABSORB: begin
              if (!absorb_ok) begin
                state_nxt = sha256_pkg::ST_ERR;
              end else if (count_r == sha256_pkg::CNT_LAST) begin
                state_nxt = sha256_pkg::ST_LOAD;
                ret_nxt   = sha256_pkg::RET_IDLE;
              end
            end
            sha256_pkg::MODE_FINISH: begin
              if (done_r) begin
                state_nxt = sha256_pkg::ST_EMIT;
              end else if (count_r == sha256_pkg::CNT_LAST) begin
                state_nxt = sha256_pkg::ST_LOAD;
                ret_nxt   = sha256_pkg::RET_PAD;
              end else begin
                state_nxt = sha256_pkg::ST_PAD;
              end
            end
            default: state_nxt = sha256_pkg::ST_IDLE;
          endcase
        end
      end
      sha256_pkg::ST_LOAD: state_nxt = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: begin
        if (rnd_r == sha256_pkg::RND_LAST) begin
          state_nxt = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        case (ret_r)
          sha256_pkg::RET_PAD:  state_nxt = sha256_pkg::ST_PAD;
          sha256_pkg::RET_DONE: state_nxt = sha256_pkg::ST_EMIT;
          default:              state_nxt = sha256_pkg::ST_IDLE;
        endcase
      end
      sha256_pkg::ST_PAD: begin
        if (count_r == sha256_pkg::LEN_POS) begin
          state_nxt = sha256_pkg::ST_LEN;
        end else if (count_r == sha256_pkg::CNT_LAST) begin
          state_nxt = sha256_pkg::ST_LOAD;
          ret_nxt   = sha256_pkg::RET_PAD;
        end
      end
      sha256_pkg::ST_LEN: begin
        if (len_r == sha256_pkg::WORD_LAST) begin
          state_nxt = sha256_pkg::ST_LOAD;
          ret_nxt   = sha256_pkg::RET_DONE;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_free && widx_r == sha256_pkg::WORD_LAST) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_ERR: begin
        if (out_free) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.shift_sel  = sha256_pkg::SH_DATA;
    cmd.len_idx    = len_r;
    cmd.round_idx  = rnd_r;
    cmd.out_idx    = widx_r;
    cmd.out_status = err_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_mode)
            sha256_pkg::MODE_ABSORB: begin
              cmd.shift_en = absorb_ok;
              cmd.tot_inc  = absorb_ok;
            end
            sha256_pkg::MODE_FINISH: begin
              cmd.shift_en  = !done_r;
              cmd.shift_sel = sha256_pkg::SH_PAD;
            end
            sha256_pkg::MODE_RESTART: cmd.restart = 1'b1;
            default: cmd.restart = 1'b0;
          endcase
        end
      end
      sha256_pkg::ST_LOAD:   cmd.load_wv = 1'b1;
      sha256_pkg::ST_ROUND:  cmd.round_en = 1'b1;
      sha256_pkg::ST_UPDATE: cmd.chain_upd = 1'b1;
      sha256_pkg::ST_PAD: begin
        cmd.shift_en  = (count_r != sha256_pkg::LEN_POS);
        cmd.shift_sel = sha256_pkg::SH_ZERO;
      end
      sha256_pkg::ST_LEN: begin
        cmd.shift_en  = 1'b1;
        cmd.shift_sel = sha256_pkg::SH_LEN;
      end
      sha256_pkg::ST_EMIT: cmd.out_load = out_free;
      sha256_pkg::ST_ERR: begin
        cmd.out_load = out_free;
        cmd.out_err  = 1'b1;
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    widx_nxt      = widx_r;
    done_nxt      = done_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    if (cmd.restart) begin
      count_nxt = '0;
      done_nxt  = 1'b0;
    end else if (cmd.shift_en) begin
      count_nxt = count_r + 6'd1;
    end
    if (state_r == sha256_pkg::ST_LEN) begin
      len_nxt = len_r + 3'd1;
    end
    if (cmd.round_en) begin
      rnd_nxt = rnd_r + 6'd1;
    end
    if (state_r == sha256_pkg::ST_EMIT && out_free) begin
      widx_nxt = widx_r + 3'd1;
    end
    if (state_r == sha256_pkg::ST_UPDATE && ret_r == sha256_pkg::RET_DONE) begin
      done_nxt = 1'b1;
    end
    if (state_r == sha256_pkg::ST_IDLE) begin
      err_nxt = done_r ? sha256_pkg::STAT_AFTER_FINISH : sha256_pkg::STAT_TOO_LONG;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      ret_r       <= sha256_pkg::RET_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      widx_r      <= '0;
      done_r      <= 1'b0;
      err_r       <= sha256_pkg::STAT_AFTER_FINISH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      rnd_r       <= rnd_nxt;
      widx_r      <= widx_nxt;
      done_r      <= done_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is loaded only into a free or draining output register.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while stalled");

  a_round_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_ROUND && rnd_r == sha256_pkg::RND_LAST)
      |=> (state_r == sha256_pkg::ST_UPDATE && rnd_r == 6'd0))
    else $error("compression did not finish after the last round");

  a_emit_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_EMIT) |-> (done_r && count_r == 6'd0))
    else $error("digest emitted before the message was closed");

  a_len_position: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_LEN) |-> (count_r[5:3] == 3'b111 && count_r[2:0] == len_r))
    else $error("length field out of place in the final block");

endmodule

`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
// Absorb: each byte is taken while idle; every 64th byte starts a compression (load,
// 64 rounds at one per cycle, chain update), during which in_tready is low.
// Finish: the pad, zero and length bytes shift in, with a pause at the length field, then one
// or two compressions and eight digest words at one per cycle unless stalled; a repeat
// gives only the words. Reset is synchronous and active low; it loads the initial hash
// values and clears the byte count, message length and finished flag. No clearing pass.
`default_nettype none

module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [4:0]  out_tuser,  // [2:0] word_index, [4:3] status
  output logic        out_tlast
);

  sha256_pkg::dp_cmd_t cmd;
  sha256_pkg::dp_sts_t sts;
  logic [2:0] word_index;
  logic [1:0] status;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sha256_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (in_tdata),
    .out_word   (out_tdata),
    .out_idx    (word_index),
    .out_status (status),
    .out_last   (out_tlast)
  );

  assign out_tuser = {status, word_index};

endmodule

`default_nettype wire

// ===== verif/tb_sha256_stream_hasher.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [60:0] LEN_MAX = {61{1'b1}};
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int TARGET_ITEMS = 460;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic [1:0]  status;
    logic        last;
  } digest_out_t;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  data;
    int unsigned gap;
    bit          drain;
  } hash_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  logic [31:0] hash_chain [0:7];
  logic [7:0]  msg_block [0:63];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;
  logic        digest_done;

  hash_cmd_t   hash_cmds [$];
  digest_out_t expected_words [$];
  hash_cmd_t   next_cmd;
  digest_out_t want;
  digest_out_t got;

  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned stall_draw = 0;
  bit          recv_quiet = 1'b0;
  bit          seq_burst = 1'b0;
  int unsigned sent_count = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  sha256_stream_hasher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = hash_chain[i];
    end
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      hash_chain[i] = hash_chain[i] + v[i];
    end
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) begin
      hash_chain[i] = START_HASH[i];
    end
    block_fill = '0;
    msg_len = '0;
    digest_done = 1'b0;
  endfunction

  function automatic void push_error(input logic [1:0] status);
    expected_words.push_back('{word: 32'd0, idx: 3'd0, status: status, last: 1'b1});
  endfunction

  function automatic void hash_step(input logic [1:0] mode, input logic [7:0] data);
    logic [63:0] bits;
    int pos;
    case (mode)
      sha256_pkg::MODE_ABSORB: begin
        if (digest_done) begin
          push_error(sha256_pkg::STAT_AFTER_FINISH);
        end else if (msg_len == LEN_MAX) begin
          push_error(sha256_pkg::STAT_TOO_LONG);
        end else begin
          msg_block[block_fill] = data;
          msg_len = msg_len + 1'b1;
          block_fill = block_fill + 1'b1;
          if (block_fill == 6'd0) begin
            compress_block();
          end
        end
      end
      sha256_pkg::MODE_FINISH: begin
        if (!digest_done) begin
          bits = {msg_len, 3'b000};
          pos = block_fill;
          msg_block[pos] = PAD_MARK;
          pos++;
          if (pos > 56) begin
            for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
            compress_block();
            pos = 0;
          end
          for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
          for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
          compress_block();
          block_fill = '0;
          digest_done = 1'b1;
        end
        for (int i = 0; i < 8; i++) begin
          expected_words.push_back('{word: hash_chain[i], idx: 3'(i),
                                     status: sha256_pkg::STAT_DIGEST, last: (i == 7)});
        end
      end
      sha256_pkg::MODE_RESTART: hash_restart();
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(input logic [1:0] mode, input logic [7:0] data,
                                    input bit drain = 1'b0);
    hash_cmd_t c;
    c.mode = mode;
    c.data = data;
    c.gap = seq_burst ? 0 : $urandom_range(0, 4);
    c.drain = drain;
    hash_cmds.push_back(c);
    sent_count++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        hash_step(in_tuser, in_tdata);
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (hash_cmds.size() != 0 &&
                   !(hash_cmds[0].drain && expected_words.size() != 0)) begin
        next_cmd = hash_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_cmd.mode;
        in_tdata <= next_cmd.data;
        send_gap <= next_cmd.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[2:0], out_tuser[4:3], out_tlast};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word=%h idx=%0d status=%0d last=%b",
                 $time, got.word, got.idx, got.status, got.last);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected word=%h idx=%0d status=%0d last=%b",
                   $time, want.word, want.idx, want.status, want.last);
          $display("%0t:          actual   word=%h idx=%0d status=%0d last=%b",
                   $time, got.word, got.idx, got.status, got.last);
          errors++;
        end
      end
      if ($urandom_range(0, 15) == 0) recv_quiet <= !recv_quiet;
      stall_draw = recv_quiet ? 0 : $urandom_range(0, 4);
      out_tready <= (stall_draw == 0);
      recv_stall <= (stall_draw != 0) ? stall_draw - 1 : 0;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int kind;
    int noise;
    bit drain;
    hash_restart();

    // The empty message, a repeated finish and an absorb after finish.
    queue_cmd(sha256_pkg::MODE_FINISH, 8'h00);
    queue_cmd(sha256_pkg::MODE_FINISH, 8'hff);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h00);
    queue_cmd(MODE_UNUSED, 8'h00);
    queue_cmd(sha256_pkg::MODE_RESTART, 8'hff);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h00);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'hff);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h5a);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'ha5);
    queue_cmd(MODE_UNUSED, 8'hff);
    queue_cmd(sha256_pkg::MODE_FINISH, 8'h00);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'hff);
    queue_cmd(sha256_pkg::MODE_RESTART, 8'h00);
    queue_cmd(sha256_pkg::MODE_FINISH, 8'h00, 1'b1);
    queue_cmd(sha256_pkg::MODE_RESTART, 8'h00);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h61);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h62);
    queue_cmd(sha256_pkg::MODE_ABSORB, 8'h63);
    queue_cmd(sha256_pkg::MODE_FINISH, 8'h00);

    while (sent_count < TARGET_ITEMS) begin
      kind = $urandom_range(0, 9);
      drain = ($urandom_range(0, 7) == 0);
      seq_burst = ($urandom_range(0, 3) == 0);
      if (kind < 8) begin
        case ($urandom_range(0, 8))
          6: len = $urandom_range(55, 57);
          7: len = $urandom_range(63, 65);
          8: len = $urandom_range(119, 121);
          default: len = $urandom_range(0, 12);
        endcase
        if (kind != 7) begin
          queue_cmd(sha256_pkg::MODE_RESTART, 8'($urandom_range(0, 255)), drain);
          drain = 1'b0;
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            queue_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)), drain);
            drain = 1'b0;
          end
          queue_cmd(sha256_pkg::MODE_ABSORB, 8'($urandom_range(0, 255)), drain);
          drain = 1'b0;
        end
        queue_cmd(sha256_pkg::MODE_FINISH, 8'($urandom_range(0, 255)), drain);
        if ($urandom_range(0, 3) == 0) begin
          queue_cmd(sha256_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
          queue_cmd(sha256_pkg::MODE_ABSORB, 8'($urandom_range(0, 255)));
        end
      end else begin
        noise = $urandom_range(1, 6);
        for (int i = 0; i < noise; i++) begin
          queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), drain);
          drain = 1'b0;
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while ((hash_cmds.size() != 0 || in_tvalid || expected_words.size() != 0) &&
           idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    if (idle_cycles < IDLE_LIMIT) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
    end else if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
